FILE: hdl/aes_pkg.sv
// package: request types, s-box table and round helpers for the aes-128 pipeline
`timescale 1ns / 1ps
package aes_pkg;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } t_in_req;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } t_out_req;

    localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
    localparam logic [0:0] CFG_KEY_LOW  = 1'b1;
    localparam int         NUM_ROUNDS   = 10;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [1:10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // byte n of a 128-bit state sits at bits 127-8n : 120-8n
    function automatic logic [7:0] get_byte(input logic [127:0] v, input int n);
        get_byte = v[127 - 8 * n -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] = SBOX[get_byte(s, 4 * ((c + r) % 4) + r)];
            end
        end
        sub_shift = t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, al;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4 * c);
            a1 = get_byte(s, 4 * c + 1);
            a2 = get_byte(s, 4 * c + 2);
            a3 = get_byte(s, 4 * c + 3);
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                                     a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
        end
        mix = t;
    endfunction

    function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rcon);
        logic [31:0] w0, w1, w2, w3, tw;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        tw = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ tw;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

endpackage

FILE: hdl/aes_round.sv
// module: one registered aes round with its own key expansion step
`timescale 1ns / 1ps
module aes_round #(
    parameter int ROUND = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [127:0] i_state,
    input  logic [127:0] i_key,
    output logic         o_valid,
    output logic [127:0] o_state,
    output logic [127:0] o_key
);

    logic [127:0] n_key;
    logic [127:0] n_state;
    logic         r_valid;
    logic [127:0] r_state;
    logic [127:0] r_key;

    always_comb begin
        n_key = aes_pkg::next_key(i_key, aes_pkg::RCON[ROUND]);
        if (ROUND < aes_pkg::NUM_ROUNDS) begin
            n_state = aes_pkg::mix(aes_pkg::sub_shift(i_state)) ^ n_key;
        end else begin
            n_state = aes_pkg::sub_shift(i_state) ^ n_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;

endmodule

FILE: hdl/aes128_block_encrypt.sv
// top: fully pipelined aes-128 encryption, one block per cycle if unstalled
// usage:
//   load the key through the config channel (index 0 = key bytes 0..7,
//   index 1 = key bytes 8..15); writes to other indexes are dropped.
//   change the key only while no request is in flight.
//   input requests carry the plaintext, output requests the ciphertext.
//   a request is taken on a clock where valid is high and stall is low.
// pipeline:
//   stage 0 registers plaintext xor key and a copy of the key, then ten
//   round stages follow, each one sbox/shift/mix/add-key plus one key step
//   (round 10 has no mix); eleven register stages in all, stage 0 loads
//   on the accepting edge. throughput is one block per cycle while the
//   output is not stalled; the round stages set that rate.
// stall:
//   the whole pipe freezes only when the output holds a result and is
//   stalled; bubbles stay in place, nothing is lost or repeated.
// reset:
//   synchronous active-low reset clears all valid bits and the key to zero.
`timescale 1ns / 1ps
module aes128_block_encrypt (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  aes_pkg::t_in_req i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output aes_pkg::t_out_req o_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [0:0]       i_cfg_index,
    input  logic [63:0]      i_cfg_data
);

    localparam int NR = aes_pkg::NUM_ROUNDS;

    logic [63:0]  r_key_high;
    logic [63:0]  r_key_low;
    logic         r_valid0;
    logic [127:0] r_state0;
    logic [127:0] r_key0;
    logic         w_en;
    logic         w_valid [0:NR];
    logic [127:0] w_state [0:NR];
    logic [127:0] w_key   [0:NR];

    // pipe advances unless the final stage holds a result that is stalled
    assign w_en        = !(w_valid[NR] && i_stall);
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                aes_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                aes_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: initial add-round-key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (w_en) begin
            r_valid0 <= i_valid;
        end
        if (w_en) begin
            r_state0 <= {i_data.plain_high, i_data.plain_low} ^ {r_key_high, r_key_low};
            r_key0   <= {r_key_high, r_key_low};
        end
    end

    assign w_valid[0] = r_valid0;
    assign w_state[0] = r_state0;
    assign w_key[0]   = r_key0;

    // round stages 1..10
    for (genvar g = 1; g <= NR; g++) begin : g_round
        aes_round #(.ROUND(g)) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g-1]),
            .i_state (w_state[g-1]),
            .i_key   (w_key[g-1]),
            .o_valid (w_valid[g]),
            .o_state (w_state[g]),
            .o_key   (w_key[g])
        );
    end

    assign o_valid            = w_valid[NR];
    assign o_data.cipher_high = w_state[NR][127:64];
    assign o_data.cipher_low  = w_state[NR][63:0];

`ifndef NO_ASSERTIONS
    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("output changed while stalled");

    // input is blocked only when the last stage is full and stalled
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without cause");

    // an accepted request shows up at the first round's input in the next cycle
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> w_valid[0])
        else $error("accepted request lost at stage 0");
`endif

endmodule

FILE: tb/aes128_block_encrypt_test.sv
// testbench: aes-128 block encryption checked against a behavioral cipher model
`timescale 1ns / 1ps
module aes128_block_encrypt_test;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 16;   // pipeline latency plus margin

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    aes_pkg::t_in_req  i_data;
    logic       o_valid;
    logic       i_stall;
    aes_pkg::t_out_req o_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [0:0] i_cfg_index;
    logic [63:0] i_cfg_data;

    aes128_block_encrypt dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // own copy of the key registers, updated at each accepted write
    logic [63:0] key_hi_copy;
    logic [63:0] key_lo_copy;
    logic [7:0]  sub_table [256];

    aes_pkg::t_in_req  plain_queue[$];     // plaintext requests waiting to be sent
    aes_pkg::t_out_req cipher_expect[$];   // ciphertexts predicted, oldest first

    int send_idle_pct;
    int recv_stall_pct;
    int error_count;
    int cycle_count;
    int sent_count;
    int checked_count;
    int key_count;

    // gf(2^8) helpers for building the s-box from scratch
    function automatic logic [7:0] gf_double(logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc ^ a;
            a = gf_double(a);
        end
        return acc;
    endfunction

    // s-box = affine transform of the multiplicative inverse
    function automatic void build_sub_table();
        logic [7:0] inv;
        logic [7:0] b;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++) begin
                if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
            end
            b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sub_table[x] = b;
        end
    endfunction

    // full ten-round cipher of one block under the current key copy
    function automatic aes_pkg::t_out_req encrypt_block(aes_pkg::t_in_req p,
                                                        logic [127:0] key);
        logic [127:0] blk;
        logic [7:0]   st [16];
        logic [7:0]   rk [16];
        logic [7:0]   tmp [16];
        logic [7:0]   a0, a1, a2, a3, all, rcon, k0;
        aes_pkg::t_out_req res;
        blk = {p.plain_high, p.plain_low};
        for (int n = 0; n < 16; n++) begin
            rk[n] = key[127 - 8 * n -: 8];
            st[n] = blk[127 - 8 * n -: 8] ^ rk[n];
        end
        rcon = 8'h01;
        for (int rnd = 1; rnd <= 10; rnd++) begin
            // sub bytes and shift rows together
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    tmp[4 * c + r] = sub_table[st[4 * ((c + r) % 4) + r]];
            st = tmp;
            if (rnd < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[4 * c]; a1 = st[4 * c + 1];
                    a2 = st[4 * c + 2]; a3 = st[4 * c + 3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    st[4 * c]     = a0 ^ all ^ gf_double(a0 ^ a1);
                    st[4 * c + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
                    st[4 * c + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
                    st[4 * c + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
                end
            end
            // key schedule step: rot word, sub word, round constant
            k0 = sub_table[rk[13]] ^ rcon;
            rk[1] = rk[1] ^ sub_table[rk[14]];
            rk[2] = rk[2] ^ sub_table[rk[15]];
            rk[3] = rk[3] ^ sub_table[rk[12]];
            rk[0] = rk[0] ^ k0;
            for (int n = 4; n < 16; n++) rk[n] = rk[n] ^ rk[n - 4];
            rcon = gf_double(rcon);
            for (int n = 0; n < 16; n++) st[n] = st[n] ^ rk[n];
        end
        for (int n = 0; n < 16; n++) blk[127 - 8 * n -: 8] = st[n];
        res.cipher_high = blk[127:64];
        res.cipher_low  = blk[63:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %016h expected %016h at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle counter and watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout: %0d ciphertexts still pending", cipher_expect.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // driver: predicts at each accepted request, then offers the next one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                cipher_expect.push_back(encrypt_block(i_data, {key_hi_copy, key_lo_copy}));
                sent_count++;
            end
            if (i_valid && o_stall) begin
                // hold the stalled request unchanged
            end else if (plain_queue.size() > 0
                         && $urandom_range(99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_data  <= plain_queue.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: compares each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (cipher_expect.size() == 0) begin
                    $display("UNEXPECTED result %016h_%016h at cycle %0d",
                             o_data.cipher_high, o_data.cipher_low, cycle_count);
                    error_count++;
                end else begin
                    aes_pkg::t_out_req want;
                    want = cipher_expect.pop_front();
                    if (o_data.cipher_high !== want.cipher_high)
                        report_mismatch("cipher_high", o_data.cipher_high, want.cipher_high);
                    if (o_data.cipher_low !== want.cipher_low)
                        report_mismatch("cipher_low", o_data.cipher_low, want.cipher_low);
                    checked_count++;
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // wait until the pipe is empty, then let it settle
    task automatic wait_drained();
        while (plain_queue.size() > 0 || cipher_expect.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_key(logic [0:0] idx, logic [63:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == aes_pkg::CFG_KEY_HIGH) key_hi_copy = value;
        else key_lo_copy = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic change_key(logic [63:0] hi, logic [63:0] lo);
        wait_drained();
        write_key(aes_pkg::CFG_KEY_HIGH, hi);
        write_key(aes_pkg::CFG_KEY_LOW, lo);
        key_count++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic queue_plain(logic [63:0] hi, logic [63:0] lo);
        aes_pkg::t_in_req p;
        p.plain_high = hi;
        p.plain_low  = lo;
        plain_queue.push_back(p);
    endtask

    // stimulus
    initial begin
        aes_pkg::t_in_req p;
        int mode;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data         = '0;
        i_stall        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = aes_pkg::CFG_KEY_HIGH;
        i_cfg_data     = '0;
        key_hi_copy    = '0;
        key_lo_copy    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        cycle_count    = 0;
        sent_count     = 0;
        checked_count  = 0;
        key_count      = 0;
        build_sub_table();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset key, then extremes of key and plaintext
        queue_plain('0, '0);
        queue_plain('1, '1);
        queue_plain(64'h8000000000000000, 64'h0000000000000001);
        wait_drained();
        change_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        queue_plain(64'h0011223344556677, 64'h8899aabbccddeeff);
        queue_plain('0, '1);
        change_key('1, '1);
        queue_plain('0, '0);
        queue_plain('1, '1);
        queue_plain(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        change_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
        queue_plain(64'h3243f6a8885a308d, 64'h313198a2e0370734);
        queue_plain(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        // key change between back-to-back bursts: only low half rewritten
        wait_drained();
        write_key(aes_pkg::CFG_KEY_LOW, '0);
        queue_plain(64'h3243f6a8885a308d, 64'h313198a2e0370734);
        change_key('0, '0);
        queue_plain(64'h0123456789abcdef, 64'hfedcba9876543210);

        // random phases, cycling through the idling patterns
        for (int ph = 0; ph < 8; ph++) begin
            change_key(ph == 7 ? '1 : rand64(), ph == 7 ? '1 : rand64());
            mode = ph % 4;
            send_idle_pct  = (mode == 1 || mode == 3) ? (mode == 1 ? 87 : 29) : 0;
            recv_stall_pct = (mode == 2 || mode == 3) ? (mode == 2 ? 87 : 29) : 0;
            for (int i = 0; i < 150; i++) begin
                case ($urandom_range(9))
                    0: queue_plain('0, rand64());
                    1: queue_plain(rand64(), '1);
                    default: queue_plain(rand64(), rand64());
                endcase
                // sender holds off mid-phase until every result is back
                if (ph == 2 && i == 75) begin
                    while (plain_queue.size() > 0 || i_valid) @(posedge i_clk);
                    while (cipher_expect.size() > 0) @(posedge i_clk);
                end
            end
            while (plain_queue.size() > 0) @(posedge i_clk);
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drained();

        $display("sent %0d plaintext blocks under %0d keys, %0d ciphertexts checked",
                 sent_count, key_count, checked_count);
        $display("idling: none, sender, receiver and both sides; %0d mismatches",
                 error_count);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
